// ===== design/fpe_pkg.sv =====
`timescale 1ns / 1ps

package fpe_pkg;

    localparam int FRAME_BYTES_DEF = 256;
    localparam logic [15:0] NO_START_OFFSET = 16'hFFFF;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_CONTENT = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] frame_counter;
        logic [15:0] first_offset;
        logic [15:0] last_offset;
        logic [7:0]  content_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  packet_byte;
        logic        packet_first;
        logic        packet_last;
        logic [15:0] packet_length;
    } result_t;

endpackage

// ===== design/fpe_in_reg.sv =====
`timescale 1ns / 1ps

module fpe_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fpe_pkg::item_t s_item,
    output logic          item_valid,
    output fpe_pkg::item_t item,
    input  logic          item_take
);

    logic           valid_reg;
    logic           valid_next;
    fpe_pkg::item_t item_reg;
    logic           s_accept;

    assign s_ready = !valid_reg || item_take;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (item_take) begin
            valid_next = 1'b0;
        end
        if (s_accept) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_accept) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

// ===== design/fpe_parser.sv =====
`timescale 1ns / 1ps

module fpe_parser #(
    parameter int FRAME_BYTES = fpe_pkg::FRAME_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  fpe_pkg::item_t   in_item,
    output logic             in_take,
    output logic             out_valid,
    input  logic             out_ready,
    output fpe_pkg::result_t out_result
);

    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam logic [16:0] FB_LIMIT = 17'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_END = POS_W'(FRAME_BYTES);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_DATA,
        PH_HDR_HI,
        PH_HDR_LO,
        PH_SEEK
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        pending;
        logic        is_last;
        logic [15:0] first_offset;
    } hdr_t;

    function automatic hdr_t enter_header(input logic [16:0] p, input logic [POS_W-1:0] fpos,
                                          input logic pending, input logic [15:0] first_off,
                                          input logic [15:0] last_off, input logic is_last);
        hdr_t        h;
        logic [16:0] target;
        h.phase = PH_SKIP;
        h.pending = pending;
        h.is_last = is_last;
        h.first_offset = first_off;
        target = p;
        if (p + 17'd2 <= FB_LIMIT) begin
            if (pending) begin
                h.pending = 1'b0;
                target = {1'b0, first_off};
            end
            if (pending && (target < p || target + 17'd2 > FB_LIMIT)) begin
                h.phase = PH_SKIP;
            end else begin
                h.is_last = (target == {1'b0, last_off});
                if (target == 17'(fpos)) begin
                    h.phase = PH_HDR_HI;
                end else begin
                    h.first_offset = target[15:0];
                    h.phase = PH_SEEK;
                end
            end
        end
        return h;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [15:0]      prev_counter_reg, prev_counter_next;
    logic [15:0]      total_reg, total_next;
    logic [15:0]      received_reg, received_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [15:0]      first_reg, first_next;
    logic [15:0]      last_reg, last_next;
    logic             pending_reg, pending_next;
    logic             is_last_reg, is_last_next;
    logic             out_valid_reg, out_valid_next;
    fpe_pkg::result_t res_reg, res_next;
    logic             emit;

    logic             gap;
    logic [15:0]      total_eff;
    logic [16:0]      start;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      new_len;
    logic [15:0]      rcv_inc;
    hdr_t             hdr;

    assign in_take = in_valid && (!out_valid_reg || out_ready);

    always_comb begin
        phase_next = phase_reg;
        prev_counter_next = prev_counter_reg;
        total_next = total_reg;
        received_next = received_reg;
        pos_next = pos_reg;
        len_hi_next = len_hi_reg;
        first_next = first_reg;
        last_next = last_reg;
        pending_next = pending_reg;
        is_last_next = is_last_reg;
        emit = 1'b0;
        res_next = '0;
        gap = (in_item.frame_counter != prev_counter_reg + 16'd1);
        total_eff = gap ? 16'd0 : total_reg;
        start = (gap && in_item.first_offset != fpe_pkg::NO_START_OFFSET)
              ? {1'b0, in_item.first_offset} : 17'd0;
        pos_inc = pos_reg + POS_W'(1);
        new_len = {len_hi_reg, in_item.content_byte};
        rcv_inc = received_reg + 16'd1;
        hdr = '0;

        if (in_take) begin
            if (in_item.op == fpe_pkg::OP_HEADER) begin
                prev_counter_next = in_item.frame_counter;
                pos_next = '0;
                first_next = in_item.first_offset;
                last_next = in_item.last_offset;
                pending_next = 1'b1;
                is_last_next = 1'b0;
                if (gap) begin
                    if (total_reg != 16'd0) begin
                        emit = 1'b1;
                        res_next.kind = fpe_pkg::KIND_ABORT;
                    end
                    total_next = '0;
                    received_next = '0;
                end
                if (gap && in_item.first_offset != fpe_pkg::NO_START_OFFSET
                        && start + 17'd2 > FB_LIMIT) begin
                    phase_next = PH_SKIP;
                end else if (total_eff == 16'd0
                        && in_item.first_offset == fpe_pkg::NO_START_OFFSET) begin
                    phase_next = PH_SKIP;
                end else if (total_eff != 16'd0) begin
                    phase_next = PH_DATA;
                end else begin
                    hdr = enter_header(start, '0, 1'b1, in_item.first_offset,
                                       in_item.last_offset, 1'b0);
                    phase_next = hdr.phase;
                    pending_next = hdr.pending;
                    is_last_next = hdr.is_last;
                    first_next = hdr.first_offset;
                    total_next = '0;
                    received_next = '0;
                end
            end else if (pos_reg < POS_END) begin
                pos_next = pos_inc;
                case (phase_reg)
                    PH_SEEK: begin
                        if (17'(pos_reg) == {1'b0, first_reg}) begin
                            len_hi_next = in_item.content_byte;
                            phase_next = PH_HDR_LO;
                        end
                    end
                    PH_HDR_HI: begin
                        len_hi_next = in_item.content_byte;
                        phase_next = PH_HDR_LO;
                    end
                    PH_HDR_LO: begin
                        total_next = new_len;
                        received_next = '0;
                        if (new_len == 16'd0) begin
                            hdr = enter_header(17'(pos_inc), pos_inc, pending_reg, first_reg,
                                               last_reg, is_last_reg);
                            phase_next = hdr.phase;
                            pending_next = hdr.pending;
                            is_last_next = hdr.is_last;
                            first_next = hdr.first_offset;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        emit = 1'b1;
                        res_next.kind = fpe_pkg::KIND_DATA;
                        res_next.packet_byte = in_item.content_byte;
                        res_next.packet_first = (rcv_inc == 16'd1);
                        res_next.packet_last = (rcv_inc == total_reg);
                        res_next.packet_length = total_reg;
                        if (rcv_inc >= total_reg) begin
                            total_next = '0;
                            received_next = '0;
                            if (is_last_reg || first_reg == fpe_pkg::NO_START_OFFSET) begin
                                phase_next = PH_SKIP;
                            end else begin
                                hdr = enter_header(17'(pos_inc), pos_inc, pending_reg,
                                                   first_reg, last_reg, is_last_reg);
                                phase_next = hdr.phase;
                                pending_next = hdr.pending;
                                is_last_next = hdr.is_last;
                                first_next = hdr.first_offset;
                            end
                        end else begin
                            received_next = rcv_inc;
                        end
                    end
                    default: begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            prev_counter_reg <= '0;
            total_reg <= '0;
            received_reg <= '0;
            pos_reg <= '0;
            len_hi_reg <= '0;
            first_reg <= '0;
            last_reg <= '0;
            pending_reg <= 1'b0;
            is_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            prev_counter_reg <= prev_counter_next;
            total_reg <= total_next;
            received_reg <= received_next;
            pos_reg <= pos_next;
            len_hi_reg <= len_hi_next;
            first_reg <= first_next;
            last_reg <= last_next;
            pending_reg <= pending_next;
            is_last_reg <= is_last_next;
            out_valid_reg <= out_valid_next;
        end
        if (emit) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_result = res_reg;

    a_data_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> total_reg != 16'd0)
        else $error("Data phase entered without a packet length.");

    a_received_below_total: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> received_reg < total_reg)
        else $error("Received count reached the packet length inside the data phase.");

    a_position_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_END)
        else $error("Frame position ran past the frame size.");

    a_data_length_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.kind == fpe_pkg::KIND_DATA |-> res_reg.packet_length != 16'd0)
        else $error("Packet byte transfer carries a zero length.");

endmodule

// ===== design/frame_to_packet_extractor_top.sv =====
`timescale 1ns / 1ps

// Frame to packet extractor. Each frame enters as one header transfer followed by
// FRAME_BYTES content transfers, and the block streams out the length-prefixed packets
// it carries, one result transfer per packet byte, plus an abort transfer when a frame
// counter gap drops an open packet. The block accepts one item per cycle unless m_ready
// back-pressure holds the output; each item passes the input register and then the
// parser, whose state update per item sets that rate.
module frame_to_packet_extractor_top #(
    parameter int FRAME_BYTES = fpe_pkg::FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_frame_counter,
    input  logic [15:0] s_first_offset,
    input  logic [15:0] s_last_offset,
    input  logic [7:0]  s_content_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_packet_byte,
    output logic        m_packet_first,
    output logic        m_packet_last,
    output logic [15:0] m_packet_length
);

    fpe_pkg::item_t   s_item;
    fpe_pkg::item_t   item;
    logic             item_valid;
    logic             item_take;
    fpe_pkg::result_t result;

    assign s_item.op = s_op;
    assign s_item.frame_counter = s_frame_counter;
    assign s_item.first_offset = s_first_offset;
    assign s_item.last_offset = s_last_offset;
    assign s_item.content_byte = s_content_byte;

    fpe_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    fpe_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (item_valid),
        .in_item    (item),
        .in_take    (item_take),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_kind = result.kind;
    assign m_packet_byte = result.packet_byte;
    assign m_packet_first = result.packet_first;
    assign m_packet_last = result.packet_last;
    assign m_packet_length = result.packet_length;

endmodule

// ===== tb/sv/fpe_packet_checker.sv =====
`timescale 1ns / 1ps

module fpe_packet_checker #(
    parameter int FRAME_BYTES = fpe_pkg::FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_frame_counter,
    input  logic [15:0] s_first_offset,
    input  logic [15:0] s_last_offset,
    input  logic [7:0]  s_content_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [7:0]  m_packet_byte,
    input  logic        m_packet_first,
    input  logic        m_packet_last,
    input  logic [15:0] m_packet_length,
    output int          mismatch_count,
    output int          pending_count,
    output int          result_count,
    output int          abort_count
);

    typedef enum logic [2:0] {
        SKIP_REST,
        IN_PAYLOAD,
        LEN_HIGH,
        LEN_LOW,
        SEEK_START
    } parse_phase_t;

    logic [15:0]  last_counter = '0;
    logic [15:0]  pkt_len = '0;
    logic [15:0]  pkt_count = '0;
    logic [15:0]  byte_pos = '0;
    parse_phase_t phase = SKIP_REST;
    logic [7:0]   len_hi = '0;
    logic [15:0]  start_off = '0;
    logic [15:0]  final_off = '0;
    logic         jump_armed = 1'b0;
    logic         on_final = 1'b0;

    fpe_pkg::result_t upcoming_results[$];

    task automatic locate_header(input int unsigned p);
        int unsigned target;
        target = p;
        pkt_len = '0;
        pkt_count = '0;
        if (p + 2 > FRAME_BYTES) begin
            phase = SKIP_REST;
        end else begin
            if (jump_armed) begin
                jump_armed = 1'b0;
                target = 32'(start_off);
            end
            if (target < p || target + 2 > FRAME_BYTES) begin
                phase = SKIP_REST;
            end else begin
                on_final = (target == 32'(final_off));
                if (target == 32'(byte_pos)) begin
                    phase = LEN_HIGH;
                end else begin
                    start_off = target[15:0];
                    phase = SEEK_START;
                end
            end
        end
    endtask

    task automatic track_frame_item(input logic op, input logic [15:0] ctr,
                                    input logic [15:0] first, input logic [15:0] last,
                                    input logic [7:0] data);
        logic [15:0] wanted;
        int unsigned start;
        int unsigned pos;
        fpe_pkg::result_t r;
        if (op == fpe_pkg::OP_HEADER) begin
            wanted = last_counter + 16'd1;
            start = 0;
            last_counter = ctr;
            byte_pos = '0;
            start_off = first;
            final_off = last;
            jump_armed = 1'b1;
            on_final = 1'b0;
            if (ctr != wanted) begin
                if (pkt_len != 16'd0) begin
                    r.kind = fpe_pkg::KIND_ABORT;
                    r.packet_byte = '0;
                    r.packet_first = 1'b0;
                    r.packet_last = 1'b0;
                    r.packet_length = '0;
                    upcoming_results.push_back(r);
                end
                pkt_len = '0;
                pkt_count = '0;
                if (first != fpe_pkg::NO_START_OFFSET) begin
                    start = 32'(first);
                end
            end
            if (ctr != wanted && first != fpe_pkg::NO_START_OFFSET
                    && first > 16'(FRAME_BYTES - 2)) begin
                phase = SKIP_REST;
            end else if (pkt_len == 16'd0 && first == fpe_pkg::NO_START_OFFSET) begin
                phase = SKIP_REST;
            end else if (pkt_len != 16'd0) begin
                phase = IN_PAYLOAD;
            end else begin
                locate_header(start);
            end
        end else if (32'(byte_pos) < FRAME_BYTES) begin
            pos = 32'(byte_pos);
            byte_pos = byte_pos + 16'd1;
            case (phase)
                SEEK_START: begin
                    if (pos == 32'(start_off)) begin
                        len_hi = data;
                        phase = LEN_LOW;
                    end
                end
                LEN_HIGH: begin
                    len_hi = data;
                    phase = LEN_LOW;
                end
                LEN_LOW: begin
                    pkt_len = {len_hi, data};
                    pkt_count = '0;
                    if (pkt_len == 16'd0) begin
                        locate_header(pos + 32'd1);
                    end else begin
                        phase = IN_PAYLOAD;
                    end
                end
                IN_PAYLOAD: begin
                    pkt_count = pkt_count + 16'd1;
                    r.kind = fpe_pkg::KIND_DATA;
                    r.packet_byte = data;
                    r.packet_first = (pkt_count == 16'd1);
                    r.packet_last = (pkt_count == pkt_len);
                    r.packet_length = pkt_len;
                    upcoming_results.push_back(r);
                    if (pkt_count >= pkt_len) begin
                        pkt_len = '0;
                        pkt_count = '0;
                        if (on_final || start_off == fpe_pkg::NO_START_OFFSET) begin
                            phase = SKIP_REST;
                        end else begin
                            locate_header(pos + 32'd1);
                        end
                    end
                end
                default: begin
                    phase = SKIP_REST;
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin
        fpe_pkg::result_t want;
        if (!aresetn) begin
            last_counter = '0;
            pkt_len = '0;
            pkt_count = '0;
            byte_pos = '0;
            phase = SKIP_REST;
            len_hi = '0;
            start_off = '0;
            final_off = '0;
            jump_armed = 1'b0;
            on_final = 1'b0;
            upcoming_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (upcoming_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected result: kind %0d byte %02h first %0d last %0d",
                                 m_kind, m_packet_byte, m_packet_first, m_packet_last);
                        $display("    length %0d", m_packet_length);
                    end
                end else begin
                    want = upcoming_results.pop_front();
                    result_count++;
                    if (want.kind == fpe_pkg::KIND_ABORT) begin
                        abort_count++;
                    end
                    if (m_kind !== want.kind || m_packet_byte !== want.packet_byte ||
                        m_packet_first !== want.packet_first ||
                        m_packet_last !== want.packet_last ||
                        m_packet_length !== want.packet_length) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Result %0d: expected kind %0d byte %02h first %0d",
                                     result_count, want.kind, want.packet_byte,
                                     want.packet_first);
                            $display("    last %0d len %0d", want.packet_last,
                                     want.packet_length);
                            $display("    got kind %0d byte %02h first %0d last %0d len %0d",
                                     m_kind, m_packet_byte, m_packet_first, m_packet_last,
                                     m_packet_length);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                track_frame_item(s_op, s_frame_counter, s_first_offset, s_last_offset,
                                 s_content_byte);
            end
        end
        pending_count = upcoming_results.size();
    end

endmodule

// ===== tb/sv/tb_frame_to_packet_extractor_top.sv =====
`timescale 1ns / 1ps

module tb_frame_to_packet_extractor_top;

    localparam int FRAME_LEN = fpe_pkg::FRAME_BYTES_DEF;
    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = fpe_pkg::OP_HEADER;
    logic [15:0] s_frame_counter = '0;
    logic [15:0] s_first_offset = '0;
    logic [15:0] s_last_offset = '0;
    logic [7:0]  s_content_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_packet_byte;
    logic        m_packet_first;
    logic        m_packet_last;
    logic [15:0] m_packet_length;

    logic [31:0] mismatches;
    logic [31:0] pending;
    logic [31:0] results;
    logic [31:0] aborts;

    int          cycle_count = 0;
    int          items_sent = 0;
    int          ignored_items = 0;
    int          frames_sent = 0;
    int          full_frames = 0;
    bit          quiet_send = 1'b0;
    int          open_left = 0;
    logic [15:0] next_counter = 16'd1;
    logic [7:0]  frame_bytes[$];
    logic [15:0] frame_first;
    logic [15:0] frame_last;

    frame_to_packet_extractor_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_frame_counter (s_frame_counter),
        .s_first_offset  (s_first_offset),
        .s_last_offset   (s_last_offset),
        .s_content_byte  (s_content_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_packet_byte   (m_packet_byte),
        .m_packet_first  (m_packet_first),
        .m_packet_last   (m_packet_last),
        .m_packet_length (m_packet_length)
    );

    fpe_packet_checker #(
        .FRAME_BYTES (FRAME_LEN)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_frame_counter (s_frame_counter),
        .s_first_offset  (s_first_offset),
        .s_last_offset   (s_last_offset),
        .s_content_byte  (s_content_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_packet_byte   (m_packet_byte),
        .m_packet_first  (m_packet_first),
        .m_packet_last   (m_packet_last),
        .m_packet_length (m_packet_length),
        .mismatch_count  (mismatches),
        .pending_count   (pending),
        .result_count    (results),
        .abort_count     (aborts)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [15:0] ctr, input logic [15:0] first,
                             input logic [15:0] last, input logic [7:0] data);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_frame_counter <= ctr;
        s_first_offset <= first;
        s_last_offset <= last;
        s_content_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_header(input logic [15:0] ctr, input logic [15:0] first,
                               input logic [15:0] last);
        send_item(fpe_pkg::OP_HEADER, ctr, first, last, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_content(input logic [7:0] data);
        send_item(fpe_pkg::OP_CONTENT, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), data);
    endtask

    initial begin
        int stall;
        int served;
        served = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = (served % 100 < 30) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
            served++;
        end
    end

    initial begin
        int lim;
        int pos;
        int plen;
        int k;
        int sel;
        int variant;
        int frame_idx;
        bit done;
        bit full;
        bit gap_next;
        logic [15:0] ctr;

        frame_idx = 0;
        gap_next = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A zero-length packet followed by a one-byte packet that is the last one.
        send_header(16'd1, 16'd0, 16'd2);
        send_content(8'h00);
        send_content(8'h00);
        send_content(8'h00);
        send_content(8'h01);
        send_content(8'hFF);
        // A long packet stays open across two short frames.
        send_header(16'd2, 16'd0, 16'd0);
        send_content(8'h01);
        send_content(8'h2C);
        send_content(8'h7F);
        send_header(16'd3, fpe_pkg::NO_START_OFFSET, 16'hFFFF);
        send_content(8'h55);
        // A counter gap drops the open packet, then parsing seeks the first offset.
        send_header(16'd9, 16'd1, 16'd1);
        send_content(8'h00);
        send_content(8'h00);
        send_content(8'h01);
        send_content(8'hEE);
        send_header(16'd10, fpe_pkg::NO_START_OFFSET, 16'd0);
        send_content(8'h12);
        send_header(16'd30, 16'd255, 16'd255);
        send_header(16'd31, 16'hFFFE, 16'hFFFF);
        send_content(8'h34);
        // The counter wraps, and the first offset lies behind the read position.
        send_header(16'hFFFF, 16'd0, 16'd0);
        send_content(8'h00);
        send_content(8'h02);
        send_header(16'h0000, 16'd0, 16'd0);
        send_content(8'h80);
        send_content(8'h81);
        send_content(8'hFF);
        next_counter = 16'd1;

        while (items_sent - ignored_items < ITEM_TARGET) begin
            frame_idx++;
            quiet_send = ($urandom_range(0, 3) == 0);
            if (frame_idx == 3 || $urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending != 0) @(negedge aclk);
            end

            full = (frame_idx == 1) || ($urandom_range(0, 11) == 0);
            frame_bytes.delete();
            frame_first = fpe_pkg::NO_START_OFFSET;
            frame_last = 16'($urandom_range(0, 65535));
            lim = full ? FRAME_LEN : $urandom_range(4, 48);
            pos = 0;
            while (pos < lim && open_left > 0) begin
                frame_bytes.push_back(8'($urandom_range(0, 255)));
                pos++;
                open_left--;
            end
            done = (open_left > 0) || (pos > 0 && $urandom_range(0, 5) == 0);
            while (!done) begin
                if (lim - pos < 2) begin
                    done = 1'b1;
                end else begin
                    sel = $urandom_range(0, 39);
                    if (sel < 4) begin
                        plen = 0;
                    end else if (sel == 4) begin
                        plen = $urandom_range(60, 300);
                    end else begin
                        plen = $urandom_range(1, 24);
                    end
                    if (frame_first == fpe_pkg::NO_START_OFFSET) begin
                        frame_first = 16'(pos);
                    end
                    frame_last = 16'(pos);
                    frame_bytes.push_back(8'(plen >> 8));
                    frame_bytes.push_back(8'(plen));
                    pos += 2;
                    k = 0;
                    while (k < plen && pos < lim) begin
                        frame_bytes.push_back(8'($urandom_range(0, 255)));
                        k++;
                        pos++;
                    end
                    open_left = plen - k;
                    done = (open_left > 0) || (pos >= lim) ||
                           (plen != 0 && $urandom_range(0, 3) == 0);
                end
            end
            while (pos < lim) begin
                frame_bytes.push_back(8'($urandom_range(0, 255)));
                pos++;
            end
            if (full) begin
                repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
                full_frames++;
            end

            variant = $urandom_range(0, 15);
            ctr = next_counter;
            if (gap_next || variant == 0) begin
                ctr = next_counter + 16'($urandom_range(1, 65535));
            end
            gap_next = 1'b0;
            case (variant)
                1: begin
                    frame_last = 16'($urandom_range(0, 65535));
                end
                2: begin
                    case ($urandom_range(0, 3))
                        0: frame_first = 16'($urandom_range(0, 65535));
                        1: frame_first = 16'($urandom_range(0, FRAME_LEN - 1));
                        2: frame_first = 16'(FRAME_LEN - 2 + $urandom_range(0, 1));
                        default: frame_first = fpe_pkg::NO_START_OFFSET;
                    endcase
                end
                3: begin
                    foreach (frame_bytes[i]) begin
                        frame_bytes[i] = 8'($urandom_range(0, 255));
                    end
                    frame_first = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535)) :
                                  16'($urandom_range(0, FRAME_LEN - 1));
                    frame_last = 16'($urandom_range(0, 65535));
                    gap_next = ($urandom_range(0, 1) == 1);
                end
                4: begin
                    send_header(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)));
                end
                default: begin
                end
            endcase
            next_counter = ctr + 16'd1;

            send_header(ctr, frame_first, frame_last);
            foreach (frame_bytes[i]) begin
                send_content(frame_bytes[i]);
                if (i >= FRAME_LEN) begin
                    ignored_items++;
                end
            end
            frames_sent++;
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d items in %0d random frames (%0d full length, %0d bytes past the end).",
                 items_sent, frames_sent, full_frames, ignored_items);
        $display("Checked %0d packet results, %0d of them aborts.", results, aborts);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
